@@ hw/rtl/slab_size_class_allocator_assert.svh @@
// assertion macros for the slab allocator checker
// no dependencies
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_ASSERT_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_ASSERT_SVH
`define SSCA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slab allocator check failed");
// a stalled word keeps its valid and its contents
`define SSCA_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, dat) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    vld && !rdy |=> vld && $stable(dat)) \
    else $error("slab allocator word changed while stalled");
`endif

@@ hw/rtl/ssca_pkg.sv @@
// shared constants and types of the slab allocator
// no dependencies
package ssca_pkg;
  localparam int unsigned ArenaBytes  = 65536;
  localparam int unsigned RegionBytes = 8192;
  localparam int unsigned MaxRegions  = 128;
  localparam int unsigned NumClasses  = 7;
  localparam int unsigned MinObjects  = 8;
  localparam int unsigned Grains      = ArenaBytes / 16;
  localparam int unsigned RegionGrains = RegionBytes / 16;
  localparam int unsigned GW          = $clog2(Grains);
  localparam int unsigned RW          = $clog2(MaxRegions);
  localparam int unsigned CW          = 3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNoClass = 3'd1;
  localparam logic [2:0] StArena   = 3'd2;
  localparam logic [2:0] StRegFull = 3'd3;
  localparam logic [2:0] StNotSlab = 3'd4;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // objects in one region of class c
  function automatic logic [GW:0] objs_of(input logic [CW-1:0] c);
    int unsigned o;
    o = RegionGrains >> c;
    if (o < MinObjects) o = MinObjects;
    return (GW+1)'(o);
  endfunction

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] granted_address;
    logic [2:0]  pool_index;
    logic [12:0] pool_in_use;
  } result_t;
endpackage

@@ hw/rtl/ssca_ram.sv @@
// generic single port write, one read port ram with registered read
// no dependencies
module ssca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hw/rtl/slab_size_class_allocator.sv @@
// slab size-class allocator: one request in, one result out
// Usage:
//  s_axis carries requests (tdata: request_size, object_address; tuser: func).
//  m_axis carries one result per request
//  (tdata: granted_address, pool_in_use; tuser: status, pool_index).
//  cfg_* writes arena_base; the user must write it only while the block is
//  idle, since the block itself does not enforce it. One request at a time.
//  A pop passes the class, pop and pop-wait states to the result; a size or
//  an address rejected at once goes from the class state to the result, a
//  full registry or arena from the pop state. A free reads the regions
//  in turn until one owns the object or none is left. A pool growth threads
//  the new region's 8 to 512 objects one after another before the pop goes on.
//  The result sits in an output register; s_axis_tready stays low until it
//  has been taken, so a stalled receiver holds the block.
//  Reset empties all pools and the region registry; the link and region
//  memories need no clearing since they are only read after being written.
module slab_size_class_allocator
  import ssca_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // request_size[31:0], object_address[79:32]
  input  logic         s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // granted_address[47:0], pool_in_use[60:48]
  output logic [5:0]   m_axis_tuser,  // status[2:0], pool_index[5:3]
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [47:0]  cfg_data_i
);
  localparam logic [3:0] SIdle = 4'd0, SClass = 4'd1, SSearch = 4'd2, SSrchW = 4'd3,
    SFree = 4'd4, SPop = 4'd5, SPopW = 4'd6, SGrow = 4'd7, SDone = 4'd8;

  logic [3:0] st_q, st_d;
  logic [47:0] base_q;
  logic func_q;
  logic [31:0] size_q;
  logic [47:0] addr_q;
  logic [CW-1:0] c_q, c_d;
  logic [GW:0] head_q [NumClasses];
  logic [12:0] used_q [NumClasses];
  logic [12:0] tot_q [NumClasses];
  logic [RW:0] rcnt_q;
  logic [GW:0] carve_q;
  logic [RW:0] ri_q;
  logic [GW:0] g_q;
  logic [GW:0] k_q;
  logic [GW-1:0] prev_q;
  result_t res_q;
  logic outv_q;

  logic link_we;
  logic [GW-1:0] link_wa, link_wd, link_ra, link_rd;
  logic reg_we;
  logic [RW-1:0] reg_ra;
  logic [2*GW+1+CW-1:0] reg_wd, reg_rd;

  ssca_ram #(.Width(GW), .Depth(Grains)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_wa), .wdata_i(link_wd),
    .raddr_i(link_ra), .rdata_o(link_rd));
  ssca_ram #(.Width(2*GW+1+CW), .Depth(MaxRegions)) u_region (
    .clk_i, .we_i(reg_we), .waddr_i(rcnt_q[RW-1:0]), .wdata_i(reg_wd),
    .raddr_i(reg_ra), .rdata_o(reg_rd));

  assign s_axis_tready = (st_q == SIdle) && !outv_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = {3'd0, res_q.pool_in_use, res_q.granted_address};
  assign m_axis_tuser  = {res_q.pool_index, res_q.status};

  logic [47:0] off;
  logic [GW:0] objs, need;
  logic [GW-1:0] rs, obj;
  logic [GW:0] re;
  logic [CW-1:0] rp;
  logic [GW:0] left;
  assign off  = addr_q - base_q;
  assign objs = objs_of(c_q);
  assign need = objs << c_q;
  assign {rp, re, rs} = reg_rd;
  assign obj  = rs + (((g_q[GW-1:0] - rs) >> rp) << rp);
  assign left = (GW+1)'(tot_q[c_q] - used_q[c_q]);
  assign reg_ra = ri_q[RW-1:0];

  always_comb begin
    c_d = '0;
    for (int i = NumClasses - 1; i >= 0; i--)
      if (size_q <= (32'd16 << i)) c_d = CW'(i);
  end

  always_comb begin
    st_d = st_q;
    link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = head_q[c_q][GW-1:0];
    reg_wd = {c_q, carve_q + need, carve_q[GW-1:0]};
    case (st_q)
      SGrow: begin
        link_we = 1'b1;
        link_wa = GW'(carve_q + (k_q << c_q));
        link_wd = prev_q;
      end
      SFree: begin
        link_we = 1'b1; link_wa = obj;
        link_wd = head_q[rp][GW] ? '0 : head_q[rp][GW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; base_q <= '0; outv_q <= 1'b0; rcnt_q <= '0; carve_q <= '0;
      for (int i = 0; i < NumClasses; i++) begin
        head_q[i] <= (GW+1)'(Grains); used_q[i] <= '0; tot_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) base_q <= cfg_data_i;
      if (outv_q && m_axis_tready) outv_q <= 1'b0;
      unique case (st_q)
        SIdle: if (s_axis_tvalid && s_axis_tready) begin
          func_q <= s_axis_tuser; size_q <= s_axis_tdata[31:0];
          addr_q <= s_axis_tdata[79:32]; st_q <= SClass;
          res_q <= '0;
          ri_q <= '0;
        end
        SClass: begin
          if (func_q == FuncFree) begin
            g_q <= (GW+1)'(off >> 4);
            if (addr_q < base_q || (off >> 4) >= 48'(Grains)) begin
              res_q.status <= StNotSlab; st_q <= SDone;
            end else st_q <= SSearch;
          end else if (size_q == 0 || size_q > (32'd16 << (NumClasses - 1))) begin
            res_q.status <= StNoClass; st_q <= SDone;
          end else begin
            c_q <= c_d; st_q <= SPop;
          end
        end
        SSearch: begin
          if (ri_q >= rcnt_q) begin
            res_q.status <= StNotSlab; st_q <= SDone;
          end else st_q <= SSrchW;
        end
        SSrchW: begin
          // region data for ri_q is now valid
          if (ri_q >= rcnt_q) begin
            res_q.status <= StNotSlab; st_q <= SDone;
          end else if ({1'b0, rs} <= g_q && g_q < re) begin
            st_q <= SFree;
          end else begin
            ri_q <= ri_q + 1'b1; st_q <= SSearch;
          end
        end
        SFree: begin
          head_q[rp] <= {1'b0, obj};
          res_q.pool_index <= rp;
          res_q.pool_in_use <= (used_q[rp] != 0) ? used_q[rp] - 1'b1 : '0;
          if (used_q[rp] != 0) used_q[rp] <= used_q[rp] - 1'b1;
          st_q <= SDone;
        end
        SPop: begin
          res_q.pool_index <= c_q;
          if (head_q[c_q] >= (GW+1)'(Grains)) begin
            if (rcnt_q >= (RW+1)'(MaxRegions)) begin
              res_q.status <= StRegFull; res_q.pool_in_use <= used_q[c_q]; st_q <= SDone;
            end else if (carve_q > (GW+1)'(Grains) || need > (GW+1)'(Grains) - carve_q) begin
              res_q.status <= StArena; res_q.pool_in_use <= used_q[c_q]; st_q <= SDone;
            end else begin
              k_q <= '0; prev_q <= '0; st_q <= SGrow;
            end
          end else st_q <= SPopW;
        end
        SGrow: begin
          prev_q <= link_wa;
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 == objs) begin
            head_q[c_q] <= {1'b0, link_wa};
            tot_q[c_q] <= tot_q[c_q] + 13'(objs);
            rcnt_q <= rcnt_q + 1'b1;
            carve_q <= carve_q + need;
            st_q <= SPop;
          end
        end
        SPopW: begin
          res_q.granted_address <= base_q + {head_q[c_q][GW-1:0], 4'd0};
          res_q.pool_in_use <= used_q[c_q] + 1'b1;
          used_q[c_q] <= used_q[c_q] + 1'b1;
          if (tot_q[c_q] <= used_q[c_q] || left <= 1)
            head_q[c_q] <= (GW+1)'(Grains);
          else head_q[c_q] <= {1'b0, link_rd};
          st_q <= SDone;
        end
        SDone: if (!outv_q) begin
          outv_q <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // region registry written once growth is known to succeed
  always_comb reg_we = (st_q == SPop) && head_q[c_q] >= (GW+1)'(Grains)
    && rcnt_q < (RW+1)'(MaxRegions) && carve_q <= (GW+1)'(Grains)
    && need <= (GW+1)'(Grains) - carve_q;
endmodule

@@ hw/rtl/ssca_checker.sv @@
// port-level checks on the slab allocator
// depends on slab_size_class_allocator_assert.svh
`include "slab_size_class_allocator_assert.svh"
module ssca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [5:0]  m_axis_tuser
);
  `SSCA_ASSERT_HOLD(a_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `SSCA_ASSERT(a_one, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `SSCA_ASSERT(a_zero, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser[2:0] != 3'd0 |-> m_axis_tdata[47:0] == 48'd0)
  `SSCA_ASSERT(a_busy, clk_i, rst_ni, m_axis_tvalid |-> !s_axis_tready)
endmodule
bind slab_size_class_allocator ssca_checker u_ssca_checker (.*);

@@ sim/tb_slab_size_class_allocator.sv @@
// testbench for the slab size-class allocator: directed table, then random phases
// depends on ssca_pkg and slab_size_class_allocator
`timescale 1ns / 1ps

module tb_slab_size_class_allocator;
  import ssca_pkg::*;

  typedef struct {
    logic        func;
    logic [31:0] size;
    logic [47:0] addr;
    bit          typed;
    result_t     res;
  } req_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [47:0] cfg_data_i;

  // allocator mirror
  logic [47:0]  base_q;
  int unsigned  link_mem [Grains];
  int unsigned  head_q   [NumClasses];
  int unsigned  used_q   [NumClasses];
  int unsigned  total_q  [NumClasses];
  int unsigned  reg_lo   [MaxRegions];
  int unsigned  reg_hi   [MaxRegions];
  int unsigned  reg_cls  [MaxRegions];
  int unsigned  reg_cnt;
  int unsigned  carve_q;

  result_t      pending_q [$];
  int unsigned  live_grain [$];
  req_row_t     dir_rows [$];
  int           tx_idle;
  int           rx_idle;
  int           rx_hold;
  int           errors;
  int           results_seen;
  int           status_seen [8];

  slab_size_class_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // applies one request to the mirror and returns the result it yields
  function automatic result_t apply_request(logic func, logic [31:0] size, logic [47:0] addr);
    result_t     r;
    int unsigned cls, c, objs, need, prev, g, nxt, left, s, obj, i;
    bit          found;
    logic [63:0] rel;
    r = '0;
    found = 1'b0;
    cls = 0;
    if (func == FuncAlloc) begin
      if (size != 0) begin
        for (c = 0; c < NumClasses; c++) begin
          if (!found && {32'd0, size} <= (64'd16 << c)) begin
            found = 1'b1;
            cls = c;
          end
        end
      end
      if (!found) begin
        r.status = StNoClass;
        return r;
      end
      if (head_q[cls] >= Grains) begin
        objs = RegionBytes / (16 << cls);
        if (objs < MinObjects) objs = MinObjects;
        need = objs << cls;
        if (reg_cnt >= MaxRegions) r.status = StRegFull;
        else if (carve_q > Grains || need > Grains - carve_q) r.status = StArena;
        if (r.status != StOk) begin
          r.pool_index = cls[2:0];
          r.pool_in_use = used_q[cls][12:0];
          return r;
        end
        reg_lo[reg_cnt] = carve_q;
        reg_hi[reg_cnt] = carve_q + need;
        reg_cls[reg_cnt] = cls;
        reg_cnt++;
        prev = 0;
        for (i = 0; i < objs; i++) begin
          g = carve_q + (i << cls);
          link_mem[g] = prev;
          prev = g;
        end
        head_q[cls] = prev;
        total_q[cls] += objs;
        carve_q += need;
      end
      g = head_q[cls];
      left = total_q[cls] - used_q[cls];
      nxt = link_mem[g];
      if (total_q[cls] <= used_q[cls] || left <= 1 || nxt >= Grains) head_q[cls] = Grains;
      else head_q[cls] = nxt;
      used_q[cls]++;
      rel = {16'd0, base_q} + (64'(g) << 4);
      r.granted_address = rel[47:0];
      r.pool_index = cls[2:0];
      r.pool_in_use = used_q[cls][12:0];
      return r;
    end
    r.status = StNotSlab;
    if (addr < base_q) return r;
    rel = {16'd0, addr - base_q} >> 4;
    if (rel >= Grains) return r;
    g = rel[31:0];
    for (i = 0; i < reg_cnt; i++) begin
      if (r.status == StNotSlab && g >= reg_lo[i] && g < reg_hi[i]) begin
        s = reg_lo[i];
        cls = reg_cls[i];
        obj = s + (((g - s) >> cls) << cls);
        link_mem[obj] = (head_q[cls] >= Grains) ? 0 : head_q[cls];
        head_q[cls] = obj;
        if (used_q[cls] > 0) used_q[cls]--;
        r.status = StOk;
        r.pool_index = cls[2:0];
        r.pool_in_use = used_q[cls][12:0];
      end
    end
    return r;
  endfunction

  task automatic send_word(logic func, logic [31:0] size, logic [47:0] addr, bit typed,
                           result_t typed_res);
    result_t     r;
    logic [47:0] rel;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, size};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_request(func, size, addr);
    if (func == FuncAlloc && r.status == StOk) begin
      rel = r.granted_address - base_q;
      live_grain.push_back(32'(rel >> 4));
    end
    pending_q.push_back(typed ? typed_res : r);
    if ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_base(logic [47:0] value);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    base_q = value;
    @(posedge clk_i);
  endtask

  task automatic random_word();
    int unsigned c, k, g;
    logic [31:0] size;
    logic [47:0] addr;
    size = $urandom();
    addr = 48'({$urandom(), $urandom()});
    if ($urandom_range(1) == 0 || live_grain.size() == 0) begin
      k = $urandom_range(99);
      c = $urandom_range(NumClasses - 1);
      if (k < 5) size = 0;
      else if (k < 12) size = (size < 1025) ? size + 1025 : size;
      else size = $urandom_range(16 << c, (c == 0) ? 1 : (8 << c) + 1);
      send_word(FuncAlloc, size, addr, 1'b0, '0);
    end else begin
      k = $urandom_range(99);
      if (k < 75) begin
        c = $urandom_range(live_grain.size() - 1);
        g = live_grain[c];
        // a few frees leave the object listed, giving double frees later
        if ($urandom_range(9) != 0) live_grain.delete(c);
        addr = base_q + {g, 4'h0} + (($urandom_range(3) == 0) ? $urandom_range(15) : 0);
      end else if (k < 90) begin
        addr = base_q + {$urandom_range(Grains - 1), 4'h0} + $urandom_range(15);
      end
      send_word(FuncFree, size, addr, 1'b0, '0);
    end
  endtask

  // result checker and receiver backpressure
  initial begin
    result_t got, want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status          = m_axis_tuser[2:0];
        got.pool_index      = m_axis_tuser[5:3];
        got.granted_address = m_axis_tdata[47:0];
        got.pool_in_use     = m_axis_tdata[60:48];
        results_seen++;
        status_seen[got.status]++;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", got);
        end else begin
          want = pending_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status %0d/%0d addr %h/%h pool %0d/%0d in_use %0d/%0d",
                       want.status, got.status, want.granted_address, got.granted_address,
                       want.pool_index, got.pool_index, want.pool_in_use, got.pool_in_use);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic add_row(logic func, logic [31:0] size, logic [47:0] addr, bit typed,
                         result_t res);
    req_row_t row;
    row.func = func;
    row.size = size;
    row.addr = addr;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  initial begin
    int unsigned c, n;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = FuncAlloc;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = 0;
    errors = 0;
    results_seen = 0;
    foreach (status_seen[c]) status_seen[c] = 0;
    base_q = '0;
    reg_cnt = 0;
    carve_q = 0;
    for (c = 0; c < NumClasses; c++) begin
      head_q[c] = Grains;
      used_q[c] = 0;
      total_q[c] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_base('0);

    // directed part: size limits, one of each class, odd frees
    add_row(FuncAlloc, 32'd0, '1, 1'b1, '{StNoClass, 48'd0, 3'd0, 13'd0});
    add_row(FuncAlloc, 32'hFFFF_FFFF, '0, 1'b1, '{StNoClass, 48'd0, 3'd0, 13'd0});
    add_row(FuncAlloc, 32'd1025, '0, 1'b1, '{StNoClass, 48'd0, 3'd0, 13'd0});
    add_row(FuncAlloc, 32'd1, '0, 1'b1, '{StOk, 48'h1ff0, 3'd0, 13'd1});
    add_row(FuncAlloc, 32'd16, '0, 1'b0, '0);
    add_row(FuncAlloc, 32'd17, '0, 1'b0, '0);
    add_row(FuncAlloc, 32'd1024, '0, 1'b0, '0);
    for (c = 2; c < 6; c++) add_row(FuncAlloc, 32'd16 << c, '0, 1'b0, '0);
    add_row(FuncFree, '1, 48'h1ff0, 1'b0, '0);
    add_row(FuncFree, '0, 48'h1fe5, 1'b0, '0);
    add_row(FuncFree, '0, 48'h1ff0, 1'b0, '0);
    add_row(FuncFree, '0, 48'h1ff0, 1'b0, '0);
    add_row(FuncFree, '0, 48'hFFFF_FFFF_FFFF, 1'b1, '{StNotSlab, 48'd0, 3'd0, 13'd0});
    add_row(FuncFree, '0, 48'h1_0000, 1'b1, '{StNotSlab, 48'd0, 3'd0, 13'd0});
    add_row(FuncFree, '0, 48'hF000, 1'b1, '{StNotSlab, 48'd0, 3'd0, 13'd0});
    add_row(FuncAlloc, 32'd8, '0, 1'b0, '0);
    foreach (dir_rows[n])
      send_word(dir_rows[n].func, dir_rows[n].size, dir_rows[n].addr, dir_rows[n].typed,
                dir_rows[n].res);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // phase one: random base, sender rarely idle, receiver mostly idle
    write_base(48'({$urandom(), $urandom()}));
    tx_idle = 19;
    rx_idle = 72;
    for (n = 0; n < 300; n++) begin
      if (n == 150) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      random_word();
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // phase two: top of the address space, so granted addresses wrap
    write_base('1);
    tx_idle = 72;
    rx_idle = 19;
    for (n = 0; n < 300; n++) random_word();
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // phase three: no idling, long receiver stall at the start
    write_base(48'({$urandom(), $urandom()}) & 48'hFFFF_FFFF_0000);
    tx_idle = 0;
    rx_idle = 0;
    rx_hold = 400;
    for (n = 0; n < 300; n++) random_word();
    s_axis_tvalid <= 1'b0;
    wait_drained();

    write_base('0);
    tx_idle = 19;
    rx_idle = 72;
    for (n = 0; n < 300; n++) random_word();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (600) @(posedge clk_i);

    $display("covered %0d results over four arena bases: ok %0d, no class %0d,",
             results_seen, status_seen[StOk], status_seen[StNoClass]);
    $display("  arena full %0d, not slab %0d, %0d regions carved, %0d mismatches",
             status_seen[StArena], status_seen[StNotSlab], reg_cnt, errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
